/* hdl/tfrs_pkg.sv */
`default_nettype none

package tfrs_pkg;

    localparam int MAX_FRAMES = 256;
    localparam int ADDR_W     = 8;
    localparam int POS_W      = 9;
    localparam int TICK_CAP   = 8;
    localparam int CNT_W      = 3;

    typedef enum logic [2:0] {
        CMD_CLEAR = 3'd0,
        CMD_LOAD  = 3'd1,
        CMD_START = 3'd2,
        CMD_STOP  = 3'd3,
        CMD_TICK  = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        MODE_ONCE  = 2'd0,
        MODE_LOOP  = 2'd1,
        MODE_COUNT = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_ADV,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [2:0]  command;
        logic [31:0] time_us;
        logic [28:0] load_id;
        logic [3:0]  load_dlc;
        logic [63:0] load_bytes;
        logic        load_dir;
        logic [1:0]  loop_choice;
        logic [7:0]  refuse_mask;
    } item_t;

    typedef struct packed {
        logic        result_kind;
        logic [31:0] out_time;
        logic [28:0] out_id;
        logic [3:0]  out_dlc;
        logic [63:0] out_bytes;
        logic        out_dir;
        logic        out_dry_run;
        logic        playing_now;
        logic [8:0]  position;
        logic [31:0] pass_count;
        logic        load_error;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [31:0] stamp;
        logic [28:0] ident;
        logic [3:0]  dlc;
        logic [63:0] bytes;
        logic        dir;
    } frame_t;

endpackage

`default_nettype wire

/* hdl/timed_frame_replay_scheduler.sv */
`default_nettype none

// Timed frame replay scheduler.
// Command channel: an item (clear, load, start, stop, tick) is taken on a
// clock edge with start high and busy low. Each result word is shown on
// result for one cycle with result_valid high; the final word of an item has
// last set. The receiver cannot stall, so results are never held back.
// Clear, load, start, stop and unknown commands give one status word on the
// next cycle. A tick checks the due time in the CHECK state, then for each
// frame passes through ADV, which reads the frame and the gap of the next
// entry from the table, and EMIT, which adds the gap to now, compares and emits.
// A tick sends at most eight frames; a tick that sends nothing is busy only
// for the CHECK state and gives one status word.
// The user must write dry_run via cfg_we/cfg_data only while the block is idle; the block has no check.
// Reset clears the fill count, cursor, playback state and pass counter; the
// table contents stay undefined until loaded, and no clearing pass is needed.

module timed_frame_replay_scheduler (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire tfrs_pkg::item_t  item,
    output logic                  result_valid,
    output tfrs_pkg::result_t     result,
    input  wire logic             cfg_we,
    input  wire logic             cfg_data
);

    tfrs_pkg::frame_t frame_mem [tfrs_pkg::MAX_FRAMES];
    logic [31:0]      gap_mem   [tfrs_pkg::MAX_FRAMES];

    tfrs_pkg::state_t             state_reg, state_next;
    logic [tfrs_pkg::POS_W-1:0]   entries_reg, entries_next;
    logic [tfrs_pkg::POS_W-1:0]   cursor_reg, cursor_next;
    logic                         active_reg, active_next;
    logic [1:0]                   mode_reg, mode_next;
    logic [31:0]                  due_reg, due_next;
    logic [31:0]                  passes_reg, passes_next;
    logic [31:0]                  prev_reg, prev_next;
    logic                         dry_reg;
    logic                         stop_reg, stop_next;
    logic [tfrs_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic                         res_valid_reg, res_valid_next;

    logic [31:0]                  now_reg, now_next;
    logic [7:0]                   mask_reg, mask_next;
    tfrs_pkg::result_t            res_reg, res_next;
    tfrs_pkg::frame_t             rd_frame_reg;
    logic [31:0]                  rd_gap_reg;

    logic                         accept;
    logic                         go;
    logic                         emit_last;
    logic [31:0]                  due_calc;
    logic [tfrs_pkg::POS_W-1:0]   cursor_inc;
    logic                         at_end;
    logic [tfrs_pkg::ADDR_W-1:0]  gap_addr;
    logic                         load_we;
    logic [31:0]                  load_gap;
    logic                         load_err;

    assign busy         = (state_reg != tfrs_pkg::ST_IDLE);
    assign accept       = start && (state_reg == tfrs_pkg::ST_IDLE);
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    assign go = active_reg && (now_reg >= due_reg) && (entries_reg != '0)
                && (cursor_reg < entries_reg);
    assign cursor_inc = cursor_reg + tfrs_pkg::POS_W'(1);
    assign at_end     = (cursor_inc >= entries_reg);
    assign gap_addr   = at_end ? '0 : cursor_inc[tfrs_pkg::ADDR_W-1:0];
    assign due_calc   = now_reg + rd_gap_reg;
    assign emit_last  = stop_reg || mask_reg[cnt_reg]
                        || (cnt_reg == tfrs_pkg::CNT_W'(tfrs_pkg::TICK_CAP - 1))
                        || (now_reg < due_calc);
    assign load_err   = (entries_reg == tfrs_pkg::POS_W'(tfrs_pkg::MAX_FRAMES));
    assign load_we    = accept && (item.command == tfrs_pkg::CMD_LOAD) && !load_err;
    assign load_gap   = (entries_reg == '0) ? 32'd0 : (item.time_us - prev_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tfrs_pkg::ST_IDLE:
            begin
                if (accept && item.command == tfrs_pkg::CMD_TICK)
                begin
                    state_next = tfrs_pkg::ST_CHECK;
                end
            end
            tfrs_pkg::ST_CHECK:
            begin
                state_next = go ? tfrs_pkg::ST_ADV : tfrs_pkg::ST_IDLE;
            end
            tfrs_pkg::ST_ADV:
            begin
                state_next = tfrs_pkg::ST_EMIT;
            end
            tfrs_pkg::ST_EMIT:
            begin
                state_next = emit_last ? tfrs_pkg::ST_IDLE : tfrs_pkg::ST_ADV;
            end
            default:
            begin
                state_next = tfrs_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        entries_next   = entries_reg;
        cursor_next    = cursor_reg;
        active_next    = active_reg;
        mode_next      = mode_reg;
        due_next       = due_reg;
        passes_next    = passes_reg;
        prev_next      = prev_reg;
        stop_next      = stop_reg;
        cnt_next       = cnt_reg;
        now_next       = now_reg;
        mask_next      = mask_reg;
        res_valid_next = 1'b0;
        res_next       = res_reg;

        unique case (state_reg)
            tfrs_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (item.command)
                        tfrs_pkg::CMD_CLEAR:
                        begin
                            entries_next = '0;
                            cursor_next  = '0;
                        end
                        tfrs_pkg::CMD_LOAD:
                        begin
                            if (!load_err)
                            begin
                                entries_next = entries_reg + tfrs_pkg::POS_W'(1);
                                prev_next    = item.time_us;
                            end
                        end
                        tfrs_pkg::CMD_START:
                        begin
                            if (entries_reg != '0)
                            begin
                                mode_next   = item.loop_choice;
                                cursor_next = '0;
                                active_next = 1'b1;
                                due_next    = item.time_us;
                            end
                        end
                        tfrs_pkg::CMD_STOP:
                        begin
                            active_next = 1'b0;
                        end
                        tfrs_pkg::CMD_TICK:
                        begin
                            now_next  = item.time_us;
                            mask_next = item.refuse_mask;
                            cnt_next  = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                    if (item.command != tfrs_pkg::CMD_TICK)
                    begin
                        res_valid_next       = 1'b1;
                        res_next             = '0;
                        res_next.playing_now = active_next;
                        res_next.position    = cursor_next;
                        res_next.pass_count  = passes_next;
                        res_next.load_error  = (item.command == tfrs_pkg::CMD_LOAD)
                                               && load_err;
                        res_next.last        = 1'b1;
                    end
                end
            end
            tfrs_pkg::ST_CHECK:
            begin
                if (!go)
                begin
                    res_valid_next       = 1'b1;
                    res_next             = '0;
                    res_next.playing_now = active_reg;
                    res_next.position    = cursor_reg;
                    res_next.pass_count  = passes_reg;
                    res_next.last        = 1'b1;
                end
            end
            tfrs_pkg::ST_ADV:
            begin
                stop_next = 1'b0;
                if (at_end)
                begin
                    if (mode_reg == tfrs_pkg::MODE_ONCE)
                    begin
                        active_next = 1'b0;
                        cursor_next = cursor_inc;
                        stop_next   = 1'b1;
                    end
                    else
                    begin
                        cursor_next = '0;
                        if (mode_reg == tfrs_pkg::MODE_COUNT)
                        begin
                            passes_next = passes_reg + 32'd1;
                        end
                    end
                end
                else
                begin
                    cursor_next = cursor_inc;
                end
            end
            tfrs_pkg::ST_EMIT:
            begin
                if (!stop_reg)
                begin
                    due_next = due_calc;
                end
                cnt_next             = cnt_reg + tfrs_pkg::CNT_W'(1);
                res_valid_next       = 1'b1;
                res_next.result_kind = 1'b1;
                res_next.out_time    = rd_frame_reg.stamp;
                res_next.out_id      = rd_frame_reg.ident;
                res_next.out_dlc     = rd_frame_reg.dlc;
                res_next.out_bytes   = rd_frame_reg.bytes;
                res_next.out_dir     = rd_frame_reg.dir;
                res_next.out_dry_run = dry_reg;
                res_next.playing_now = active_reg;
                res_next.position    = cursor_reg;
                res_next.pass_count  = passes_reg;
                res_next.load_error  = 1'b0;
                res_next.last        = emit_last;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tfrs_pkg::ST_IDLE;
            entries_reg   <= '0;
            cursor_reg    <= '0;
            active_reg    <= 1'b0;
            mode_reg      <= tfrs_pkg::MODE_ONCE;
            due_reg       <= '0;
            passes_reg    <= '0;
            prev_reg      <= '0;
            dry_reg       <= 1'b0;
            stop_reg      <= 1'b0;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            entries_reg   <= entries_next;
            cursor_reg    <= cursor_next;
            active_reg    <= active_next;
            mode_reg      <= mode_next;
            due_reg       <= due_next;
            passes_reg    <= passes_next;
            prev_reg      <= prev_next;
            stop_reg      <= stop_next;
            cnt_reg       <= cnt_next;
            res_valid_reg <= res_valid_next;
            if (cfg_we)
            begin
                dry_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg  <= now_next;
        mask_reg <= mask_next;
        res_reg  <= res_next;
    end

    // frame table: one write port (load), read at cursor and next entry
    always_ff @(posedge clk)
    begin
        if (load_we)
        begin
            frame_mem[entries_reg[tfrs_pkg::ADDR_W-1:0]] <= '{
                stamp: item.time_us,
                ident: item.load_id,
                dlc:   item.load_dlc,
                bytes: item.load_bytes,
                dir:   item.load_dir
            };
            gap_mem[entries_reg[tfrs_pkg::ADDR_W-1:0]] <= load_gap;
        end
        if (state_reg == tfrs_pkg::ST_ADV)
        begin
            rd_frame_reg <= frame_mem[cursor_reg[tfrs_pkg::ADDR_W-1:0]];
            rd_gap_reg   <= gap_mem[gap_addr];
        end
    end

endmodule

`default_nettype wire

/* dv/timed_frame_replay_scheduler_tb.sv */
`default_nettype none

module timed_frame_replay_scheduler_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] CMD_SPARE_LO = 3'd5;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;
    localparam logic [1:0] MODE_LOOP_QUIET = 2'd3;
    localparam int STALL_LIMIT = 1000;
    localparam logic [31:0] T_MAX = 32'hFFFF_FFFF;

    class replay_scoreboard;
        logic [31:0] frame_stamp [tfrs_pkg::MAX_FRAMES];
        logic [28:0] frame_id    [tfrs_pkg::MAX_FRAMES];
        logic [3:0]  frame_dlc   [tfrs_pkg::MAX_FRAMES];
        logic [63:0] frame_bytes [tfrs_pkg::MAX_FRAMES];
        logic        frame_dir   [tfrs_pkg::MAX_FRAMES];
        logic [31:0] frame_gap   [tfrs_pkg::MAX_FRAMES];
        int unsigned fill;
        int unsigned cursor;
        bit          playing;
        logic [1:0]  mode;
        logic [31:0] due;
        logic [31:0] passes;
        logic [31:0] prev_stamp;
        bit          dry_run;
        tfrs_pkg::result_t expected_words [$];
        int unsigned fail_count;

        function new();
            fill = 0;
            cursor = 0;
            playing = 0;
            mode = tfrs_pkg::MODE_ONCE;
            due = '0;
            passes = '0;
            prev_stamp = '0;
            dry_run = 0;
            fail_count = 0;
        endfunction

        function tfrs_pkg::result_t make_word(bit is_frame, int unsigned idx, bit err);
            tfrs_pkg::result_t w;
            w = '0;
            if (is_frame)
            begin
                w.result_kind = 1'b1;
                w.out_time    = frame_stamp[idx];
                w.out_id      = frame_id[idx];
                w.out_dlc     = frame_dlc[idx];
                w.out_bytes   = frame_bytes[idx];
                w.out_dir     = frame_dir[idx];
                w.out_dry_run = dry_run;
            end
            w.playing_now = playing;
            w.position    = 9'(cursor);
            w.pass_count  = passes;
            w.load_error  = err;
            return w;
        endfunction

        function void predict_words(tfrs_pkg::item_t it);
            tfrs_pkg::result_t words [$];
            tfrs_pkg::result_t w;
            logic [31:0]       now;
            int unsigned       idx;
            bit                err;
            now = it.time_us;
            err = 0;
            case (it.command)
                tfrs_pkg::CMD_CLEAR:
                begin
                    fill = 0;
                    cursor = 0;
                end
                tfrs_pkg::CMD_LOAD:
                begin
                    if (fill >= tfrs_pkg::MAX_FRAMES)
                        err = 1;
                    else
                    begin
                        frame_stamp[fill] = now;
                        frame_id[fill]    = it.load_id;
                        frame_dlc[fill]   = it.load_dlc;
                        frame_bytes[fill] = it.load_bytes;
                        frame_dir[fill]   = it.load_dir;
                        frame_gap[fill]   = (fill == 0) ? 32'd0 : now - prev_stamp;
                        prev_stamp = now;
                        fill++;
                    end
                end
                tfrs_pkg::CMD_START:
                begin
                    if (fill != 0)
                    begin
                        mode = it.loop_choice;
                        cursor = 0;
                        playing = 1;
                        due = now;
                    end
                end
                tfrs_pkg::CMD_STOP:
                    playing = 0;
                tfrs_pkg::CMD_TICK:
                begin
                    while (fill != 0 && playing && now >= due
                           && words.size() < tfrs_pkg::TICK_CAP && cursor < fill)
                    begin
                        idx = cursor;
                        cursor = idx + 1;
                        if (cursor >= fill)
                        begin
                            if (mode == tfrs_pkg::MODE_ONCE)
                            begin
                                playing = 0;
                                words.push_back(make_word(1, idx, 0));
                                break;
                            end
                            cursor = 0;
                            if (mode == tfrs_pkg::MODE_COUNT)
                                passes++;
                        end
                        due = now + frame_gap[cursor];
                        words.push_back(make_word(1, idx, 0));
                        if (it.refuse_mask[words.size() - 1])
                            break;
                    end
                end
                default: ;
            endcase
            if (words.size() == 0)
                words.push_back(make_word(0, 0, err));
            foreach (words[i])
            begin
                w = words[i];
                w.last = (i == words.size() - 1);
                expected_words.push_back(w);
            end
        endfunction

        function void compare_field(string field, logic [63:0] want, logic [63:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0h, got %0h", field, want, got);
                fail_count++;
            end
        endfunction

        function void check_word(tfrs_pkg::result_t got);
            tfrs_pkg::result_t want;
            if (expected_words.size() == 0)
            begin
                $error("result word with nothing expected: %h", got);
                fail_count++;
                return;
            end
            want = expected_words.pop_front();
            compare_field("result_kind", want.result_kind, got.result_kind);
            compare_field("out_time", want.out_time, got.out_time);
            compare_field("out_id", want.out_id, got.out_id);
            compare_field("out_dlc", want.out_dlc, got.out_dlc);
            compare_field("out_bytes", want.out_bytes, got.out_bytes);
            compare_field("out_dir", want.out_dir, got.out_dir);
            compare_field("out_dry_run", want.out_dry_run, got.out_dry_run);
            compare_field("playing_now", want.playing_now, got.playing_now);
            compare_field("position", want.position, got.position);
            compare_field("pass_count", want.pass_count, got.pass_count);
            compare_field("load_error", want.load_error, got.load_error);
            compare_field("last", want.last, got.last);
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n;
    logic              start;
    logic              busy;
    tfrs_pkg::item_t   item;
    logic              result_valid;
    tfrs_pkg::result_t result;
    logic              cfg_we;
    logic              cfg_data;

    replay_scoreboard board;
    int idle_pct;
    int stall_cycles = 0;

    always #2 clk = ~clk;

    timed_frame_replay_scheduler dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data)
    );

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && result_valid === 1'b1)
            board.check_word(result);
        if ((start && !busy) || result_valid === 1'b1)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic logic [7:0] pick_mask();
        return ($urandom_range(0, 2) == 0) ? 8'($urandom()) : 8'h00;
    endfunction

    function automatic tfrs_pkg::item_t rand_item();
        tfrs_pkg::item_t it;
        it.command     = 3'($urandom_range(0, 7));
        it.time_us     = $urandom();
        it.load_id     = 29'($urandom());
        it.load_dlc    = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15))
                                                     : 4'($urandom_range(0, 8));
        it.load_bytes  = {$urandom(), $urandom()};
        it.load_dir    = 1'($urandom());
        it.loop_choice = 2'($urandom());
        it.refuse_mask = pick_mask();
        return it;
    endfunction

    task automatic push_item(tfrs_pkg::item_t it);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        item  <= it;
        do
            @(posedge clk);
        while (busy);
        board.predict_words(it);
    endtask

    task automatic issue(logic [2:0] cmd, logic [31:0] now, logic [1:0] choice,
                         logic [7:0] mask);
        tfrs_pkg::item_t it;
        it = rand_item();
        it.command     = cmd;
        it.time_us     = now;
        it.loop_choice = choice;
        it.refuse_mask = mask;
        push_item(it);
    endtask

    task automatic load_frame(logic [31:0] stamp, logic [28:0] id, logic [3:0] dlc,
                              logic [63:0] bytes, logic dir);
        tfrs_pkg::item_t it;
        it = rand_item();
        it.command    = tfrs_pkg::CMD_LOAD;
        it.time_us    = stamp;
        it.load_id    = id;
        it.load_dlc   = dlc;
        it.load_bytes = bytes;
        it.load_dir   = dir;
        push_item(it);
    endtask

    task automatic settle();
        start <= 1'b0;
        do
            @(posedge clk);
        while (board.expected_words.size() != 0 || busy);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_dry_run(bit v);
        settle();
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        board.dry_run = v;
    endtask

    initial
    begin
        int          random_items;
        int          seq;
        int          guard;
        logic [31:0] t;
        logic [31:0] stamp;

        rst_n    = 1'b0;
        start    = 1'b0;
        item     = '0;
        cfg_we   = 1'b0;
        cfg_data = 1'b0;
        idle_pct = 10;
        board    = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_dry_run(1'b1);

        // empty table: tick, start and stop do nothing; spare opcodes
        issue(tfrs_pkg::CMD_TICK, 32'd0, tfrs_pkg::MODE_ONCE, 8'h00);
        issue(tfrs_pkg::CMD_START, 32'd50, tfrs_pkg::MODE_LOOP, 8'h00);
        issue(tfrs_pkg::CMD_STOP, 32'd0, tfrs_pkg::MODE_ONCE, 8'h00);
        issue(CMD_SPARE_LO, T_MAX, tfrs_pkg::MODE_ONCE, 8'hFF);
        issue(CMD_SPARE_HI, 32'd0, tfrs_pkg::MODE_ONCE, 8'h00);
        issue(tfrs_pkg::CMD_CLEAR, 32'd0, tfrs_pkg::MODE_ONCE, 8'h00);

        // stamp wraps between first and second frame; dlc above 8
        load_frame(32'hFFFF_FFF0, '1, 4'd8, '1, 1'b1);
        load_frame(32'h0000_0010, '0, 4'd0, '0, 1'b0);
        load_frame(32'h0000_0010, 29'h0ABC_DEF1, 4'd15, 64'h0123_4567_89AB_CDEF, 1'b1);
        load_frame(32'h0000_0030, 29'h1555_5555, 4'd9, 64'hA5A5_5A5A_F00F_0FF0, 1'b0);

        issue(tfrs_pkg::CMD_START, 32'd1000, tfrs_pkg::MODE_ONCE, 8'h00);
        issue(tfrs_pkg::CMD_TICK, 32'd999, tfrs_pkg::MODE_ONCE, 8'h00);
        issue(tfrs_pkg::CMD_TICK, 32'd1000, tfrs_pkg::MODE_ONCE, 8'h00);
        issue(tfrs_pkg::CMD_TICK, 32'd1032, tfrs_pkg::MODE_ONCE, 8'h00);
        issue(tfrs_pkg::CMD_TICK, T_MAX, tfrs_pkg::MODE_ONCE, 8'h00);
        issue(tfrs_pkg::CMD_TICK, T_MAX, tfrs_pkg::MODE_ONCE, 8'h00);

        // counted loop, refusal mid-tick, then a full tick across the wrap
        issue(tfrs_pkg::CMD_START, 32'd0, tfrs_pkg::MODE_COUNT, 8'h00);
        issue(tfrs_pkg::CMD_TICK, T_MAX, tfrs_pkg::MODE_ONCE, 8'h04);
        issue(tfrs_pkg::CMD_TICK, T_MAX, tfrs_pkg::MODE_ONCE, 8'h00);
        issue(tfrs_pkg::CMD_START, 32'd5, MODE_LOOP_QUIET, 8'h00);
        issue(tfrs_pkg::CMD_TICK, T_MAX, tfrs_pkg::MODE_ONCE, 8'h80);
        issue(tfrs_pkg::CMD_STOP, 32'd0, tfrs_pkg::MODE_ONCE, 8'h00);
        issue(tfrs_pkg::CMD_TICK, T_MAX, tfrs_pkg::MODE_ONCE, 8'h00);

        // clear keeps playback active
        issue(tfrs_pkg::CMD_START, 32'd7, tfrs_pkg::MODE_LOOP, 8'h00);
        issue(tfrs_pkg::CMD_CLEAR, 32'd0, tfrs_pkg::MODE_ONCE, 8'h00);
        issue(tfrs_pkg::CMD_TICK, T_MAX, tfrs_pkg::MODE_ONCE, 8'h00);
        load_frame(32'h0000_1234, 29'h0000_0001, 4'd1, 64'h0000_0000_0000_0080, 1'b1);
        issue(tfrs_pkg::CMD_TICK, T_MAX, tfrs_pkg::MODE_ONCE, 8'hFF);
        issue(tfrs_pkg::CMD_TICK, T_MAX, tfrs_pkg::MODE_ONCE, 8'h00);
        issue(tfrs_pkg::CMD_STOP, 32'd0, tfrs_pkg::MODE_ONCE, 8'h00);

        // full table, refused load, play once to the end, then counted loop
        write_dry_run(1'b0);
        idle_pct = 0;
        issue(tfrs_pkg::CMD_CLEAR, 32'd0, tfrs_pkg::MODE_ONCE, 8'h00);
        stamp = $urandom();
        repeat (tfrs_pkg::MAX_FRAMES)
        begin
            stamp += ($urandom_range(0, 7) == 0) ? 32'd1 : 32'd0;
            issue(tfrs_pkg::CMD_LOAD, stamp, tfrs_pkg::MODE_ONCE, 8'h00);
        end
        issue(tfrs_pkg::CMD_LOAD, stamp, tfrs_pkg::MODE_ONCE, 8'h00);
        issue(tfrs_pkg::CMD_START, 32'd0, tfrs_pkg::MODE_ONCE, 8'h00);
        guard = 0;
        while (board.playing && guard < 300)
        begin
            issue(tfrs_pkg::CMD_TICK, T_MAX, tfrs_pkg::MODE_ONCE, 8'h00);
            guard++;
        end
        issue(tfrs_pkg::CMD_START, 32'd0, tfrs_pkg::MODE_COUNT, 8'h00);
        repeat (40) issue(tfrs_pkg::CMD_TICK, T_MAX, tfrs_pkg::MODE_ONCE, 8'h00);
        issue(tfrs_pkg::CMD_STOP, 32'd0, tfrs_pkg::MODE_ONCE, 8'h00);
        write_dry_run(1'b1);

        random_items = 0;
        seq = 0;
        while (random_items < 150)
        begin
            seq++;
            if (seq == 8)
                write_dry_run(1'b0);
            if (seq == 16)
                write_dry_run(1'b1);
            idle_pct = (seq >= 10 && seq < 14) ? 0 : 10;
            if ($urandom_range(0, 9) == 0)
            begin
                repeat ($urandom_range(1, 3))
                begin
                    push_item(rand_item());
                    random_items++;
                end
            end
            else
            begin
                if ($urandom_range(0, 4) != 0)
                begin
                    issue(tfrs_pkg::CMD_CLEAR, $urandom(), 2'($urandom()), pick_mask());
                    random_items++;
                end
                stamp = $urandom();
                repeat (($urandom_range(0, 9) == 0) ? $urandom_range(11, 40)
                                                    : $urandom_range(1, 10))
                begin
                    stamp += ($urandom_range(0, 19) == 0) ? $urandom() : $urandom_range(0, 20);
                    issue(tfrs_pkg::CMD_LOAD, stamp, 2'($urandom()), pick_mask());
                    random_items++;
                end
                t = ($urandom_range(0, 7) == 0) ? T_MAX - $urandom_range(0, 60) : $urandom();
                issue(tfrs_pkg::CMD_START, t, 2'($urandom()), pick_mask());
                random_items++;
                repeat ($urandom_range(3, 12))
                begin
                    t += $urandom_range(0, 25);
                    case ($urandom_range(0, 19))
                        0: issue(tfrs_pkg::CMD_STOP, t, 2'($urandom()), pick_mask());
                        1: issue(tfrs_pkg::CMD_START, t, 2'($urandom()), pick_mask());
                        2:
                        begin
                            stamp += $urandom_range(0, 20);
                            issue(tfrs_pkg::CMD_LOAD, stamp, 2'($urandom()), pick_mask());
                        end
                        default: issue(tfrs_pkg::CMD_TICK, t, 2'($urandom()), pick_mask());
                    endcase
                    random_items++;
                end
            end
        end

        settle();
        repeat (20) @(posedge clk);
        if (board.fail_count == 0 && board.expected_words.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
hdl/tfrs_pkg.sv
hdl/timed_frame_replay_scheduler.sv
dv/timed_frame_replay_scheduler_tb.sv
